FILE: src/pfe_pkg.sv
`default_nettype none
package pfe_pkg;

  localparam int WORD_W            = 32;
  localparam int CHAR_W            = 8;
  localparam int STACK_DEPTH_DEF   = 32;
  localparam int STATUS_W          = 3;
  localparam int OUT_TDATA_W       = 40;

  // Characters of interest
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_LEFTOVER  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_FULL      = 3'd4,
    ST_BADCHAR   = 3'd5
  } status_t;

endpackage
`default_nettype wire

FILE: src/pfe_div.sv
`default_nettype none
// Signed 32-bit divider, truncates toward zero, one quotient bit per cycle.
module pfe_div
  import pfe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output logic                   done,
  output logic      [WORD_W-1:0] quotient
);

  localparam int SW = $clog2(WORD_W);

  logic              busy;
  logic [SW-1:0]     step;
  logic [WORD_W:0]   rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] mb;
  logic              neg;

  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   diff;
  logic              qbit;
  logic [WORD_W:0]   rem_next;

  // One restoring step: shift in next dividend bit, try subtract
  always_comb begin
    rem_sh   = {rem[WORD_W-1:0], quo[WORD_W-1]};
    diff     = rem_sh - {1'b0, mb};
    qbit     = ~diff[WORD_W];
    rem_next = qbit ? diff : rem_sh;
  end

  assign quotient = neg ? (WORD_W'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      done <= 1'b0;
      rem  <= '0;
      quo  <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
      mb   <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
      neg  <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
    end else if (busy) begin
      rem  <= rem_next;
      quo  <= {quo[WORD_W-2:0], qbit};
      step <= step + 1'b1;
      done <= (step == SW'(WORD_W - 1));
      if (step == SW'(WORD_W - 1)) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: src/postfix_expression_evaluator_unit.sv
`default_nettype none
// Postfix evaluator: one character word per accept, result word on the final character.
// Digit or space: IDLE, EXEC. Operator: IDLE, EXEC, OP, OPRD; an open number is pushed
// in EXEC; division then waits in DIV for the bit-serial divider. The final character
// passes FLUSH and FIN before the result is loaded into the output register. One character in flight.
// Synchronous reset clears control state; stack memory contents are left as they are.
module postfix_expression_evaluator_unit
  import pfe_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [CHAR_W-1:0]      s_axis_tdata,  // [7:0] ch
  input  wire logic                   s_axis_tlast,  // last
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata   // [31:0] value, [34:32] status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_OP,
    S_OPRD,
    S_DIV,
    S_FLUSH,
    S_FIN
  } state_t;

  state_t            state;
  logic [CHAR_W-1:0] ch_q;
  logic              last_q;
  logic [WORD_W-1:0] top;
  logic [CW-1:0]     cnt;
  logic [WORD_W-1:0] acc;
  logic              in_number;
  status_t           err;

  // Operand stack below the top entry
  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rdata;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;

  logic              is_digit;
  logic              is_op;
  logic              full;
  logic              push_req;
  logic [WORD_W-1:0] acc_base;
  logic [WORD_W-1:0] acc_next;
  state_t            post_state;
  status_t           fin_status;

  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_q;

  // Decode the held character
  always_comb begin
    is_digit = ch_q inside {[CH_ZERO:CH_NINE]};
    is_op    = ch_q inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    full     = (cnt == CW'(STACK_DEPTH));
    acc_base = in_number ? acc : '0;
    acc_next = (acc_base << 3) + (acc_base << 1) +
               WORD_W'(ch_q - CH_ZERO);
    post_state = last_q ? S_FLUSH : S_IDLE;
  end

  // Flush an open number onto the stack
  always_comb begin
    push_req = 1'b0;
    if (state == S_EXEC && err == ST_OK && in_number &&
        (is_op || ch_q == CH_SPACE)) begin
      push_req = 1'b1;
    end
    if (state == S_FLUSH && err == ST_OK && in_number) begin
      push_req = 1'b1;
    end
  end

  // Spill top into memory on push; read left operand for an operator
  always_comb begin
    wr_en     = push_req && !full && (cnt != '0);
    wr_addr   = AW'(cnt - 1'b1);
    rd_en     = (state == S_OP) && (err == ST_OK) && (cnt >= CW'(2));
    rd_addr   = AW'(cnt - CW'(2));
    div_start = (state == S_OPRD) && (ch_q == CH_SLASH) && (top != '0);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  pfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rdata),
    .divisor  (top),
    .done     (div_done),
    .quotient (div_q)
  );

  // Final status from latched error and stack depth
  always_comb begin
    if (err != ST_OK) begin
      fin_status = err;
    end else if (cnt == '0) begin
      fin_status = ST_UNDERFLOW;
    end else if (cnt > CW'(1)) begin
      fin_status = ST_LEFTOVER;
    end else begin
      fin_status = ST_OK;
    end
  end

  assign s_axis_tready = (state == S_IDLE);

  // Sequencer, stack top, accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      acc           <= '0;
      in_number     <= 1'b0;
      err           <= ST_OK;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Drop the result word once taken, unless a new one loads now
      if (m_axis_tvalid && m_axis_tready && state != S_FIN) begin
        m_axis_tvalid <= 1'b0;
      end

      // Shared push: full stack latches an error, otherwise grow
      if (push_req) begin
        in_number <= 1'b0;
        if (full) begin
          err <= ST_FULL;
        end else begin
          top <= acc;
          cnt <= cnt + 1'b1;
        end
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            ch_q   <= s_axis_tdata;
            last_q <= s_axis_tlast;
            state  <= S_EXEC;
          end
        end

        S_EXEC: begin
          state <= post_state;
          if (err == ST_OK) begin
            if (is_digit) begin
              acc       <= acc_next;
              in_number <= 1'b1;
            end else if (ch_q == CH_SPACE) begin
              // push handled above
            end else if (is_op) begin
              if (!(in_number && full)) begin
                state <= S_OP;
              end
            end else begin
              err <= ST_BADCHAR;
            end
          end
        end

        S_OP: begin
          if (cnt < CW'(2)) begin
            err   <= ST_UNDERFLOW;
            state <= post_state;
          end else begin
            state <= S_OPRD;
          end
        end

        S_OPRD: begin
          state <= post_state;
          case (ch_q)
            CH_PLUS: begin
              top <= rdata + top;
              cnt <= cnt - 1'b1;
            end
            CH_MINUS: begin
              top <= rdata - top;
              cnt <= cnt - 1'b1;
            end
            CH_STAR: begin
              top <= WORD_W'(rdata * top);
              cnt <= cnt - 1'b1;
            end
            default: begin
              if (top == '0) begin
                err <= ST_DIVZERO;
              end else begin
                state <= S_DIV;
              end
            end
          endcase
        end

        S_DIV: begin
          if (div_done) begin
            top   <= div_q;
            cnt   <= cnt - 1'b1;
            state <= post_state;
          end
        end

        S_FLUSH: begin
          state <= S_FIN;
        end

        S_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {5'b0, fin_status,
                              (fin_status == ST_OK) ? top : WORD_W'(0)};
            cnt           <= '0;
            acc           <= '0;
            in_number     <= 1'b0;
            err           <= ST_OK;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: dv/postfix_eval_checker.sv
`timescale 1ns / 1ps
module postfix_eval_checker
  import pfe_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  input  wire logic                   s_axis_tready,
  input  wire logic [CHAR_W-1:0]      s_axis_tdata,  // [7:0] ch
  input  wire logic                   s_axis_tlast,  // last
  input  wire logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] value, [34:32] status
  output int                          mismatches,
  output int                          answers_due
);

  typedef struct packed {
    logic [WORD_W-1:0] value;
    status_t           status;
  } answer_t;

  // Shadow copy of the evaluator state
  logic [WORD_W-1:0] operands [DEPTH];
  int                depth_used;
  logic [WORD_W-1:0] number_acc;
  logic              digits_open;
  status_t           err_latched;

  answer_t predicted_answers[$];
  answer_t want;

  task automatic report(input string field, input logic [WORD_W-1:0] got,
                        input logic [WORD_W-1:0] exp_val);
    $display("%0t: ERROR result word %s: got %0h, want %0h", $time, field, got, exp_val);
    mismatches++;
  endtask

  task automatic clear_state();
    depth_used  = 0;
    number_acc  = '0;
    digits_open = 1'b0;
    err_latched = ST_OK;
  endtask

  // Keep only the first error of an expression
  task automatic latch_error(input status_t code);
    if (err_latched == ST_OK) err_latched = code;
  endtask

  task automatic push_operand(input logic [WORD_W-1:0] v);
    if (depth_used >= DEPTH) begin
      latch_error(ST_FULL);
    end else begin
      operands[depth_used] = v;
      depth_used++;
    end
  endtask

  task automatic close_number();
    if (digits_open) begin
      digits_open = 1'b0;
      push_operand(number_acc);
    end
  endtask

  // Divide magnitudes, then restore the sign; most negative by minus one wraps
  function automatic logic [WORD_W-1:0] quotient(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] ma, mb, q;
    ma = a[WORD_W-1] ? -a : a;
    mb = b[WORD_W-1] ? -b : b;
    q  = ma / mb;
    return (a[WORD_W-1] != b[WORD_W-1]) ? -q : q;
  endfunction

  task automatic apply_operator(input logic [CHAR_W-1:0] op);
    logic [WORD_W-1:0] lhs, rhs, res;
    close_number();
    if (err_latched == ST_OK) begin
      if (depth_used < 2) begin
        latch_error(ST_UNDERFLOW);
      end else begin
        rhs = operands[depth_used-1];
        lhs = operands[depth_used-2];
        if (op == CH_SLASH && rhs == '0) begin
          latch_error(ST_DIVZERO);
        end else begin
          case (op)
            CH_PLUS:  res = lhs + rhs;
            CH_MINUS: res = lhs - rhs;
            CH_STAR:  res = lhs * rhs;
            default:  res = quotient(lhs, rhs);
          endcase
          depth_used -= 2;
          push_operand(res);
        end
      end
    end
  endtask

  // Advance the shadow state by one character; queue an answer on the final one
  task automatic eval_char(input logic [CHAR_W-1:0] c, input logic is_last);
    answer_t ans;
    if (err_latched == ST_OK) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (!digits_open) begin
          number_acc  = '0;
          digits_open = 1'b1;
        end
        number_acc = number_acc * 32'd10 + WORD_W'(c - CH_ZERO);
      end else if (c == CH_SPACE) begin
        close_number();
      end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
        apply_operator(c);
      end else begin
        latch_error(ST_BADCHAR);
      end
    end
    if (is_last) begin
      if (err_latched == ST_OK) close_number();
      ans.value = '0;
      if (err_latched != ST_OK)  ans.status = err_latched;
      else if (depth_used == 0)  ans.status = ST_UNDERFLOW;
      else if (depth_used > 1)   ans.status = ST_LEFTOVER;
      else                       ans.status = ST_OK;
      if (ans.status == ST_OK) ans.value = operands[0];
      predicted_answers.push_back(ans);
      clear_state();
    end
  endtask

  // Watch both channels; compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      predicted_answers.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) eval_char(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_answers.size() == 0) begin
          report("with nothing pending", m_axis_tdata[WORD_W-1:0], '0);
        end else begin
          want = predicted_answers.pop_front();
          if (m_axis_tdata[WORD_W-1:0] !== want.value)
            report("value", m_axis_tdata[WORD_W-1:0], want.value);
          if (m_axis_tdata[WORD_W +: STATUS_W] !== want.status)
            report("status", WORD_W'(m_axis_tdata[WORD_W +: STATUS_W]),
                   WORD_W'(want.status));
        end
      end
    end
    answers_due <= predicted_answers.size();
  end

endmodule

FILE: dv/postfix_expression_evaluator_unit_tb.sv
`timescale 1ns / 1ps
module postfix_expression_evaluator_unit_tb;
  import pfe_pkg::*;

  localparam int CHARS_TARGET = 1600;
  localparam int PHASE_CHARS  = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic [CHAR_W-1:0]      s_axis_tdata  = '0;  // [7:0] ch
  logic                   s_axis_tlast  = 1'b0;  // last
  logic                   m_axis_tready = 1'b0;
  wire                    s_axis_tready;
  wire                    m_axis_tvalid;
  wire [OUT_TDATA_W-1:0]  m_axis_tdata;  // [31:0] value, [34:32] status

  int   mismatches;
  int   answers_due;
  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  logic hold_req      = 1'b0;
  logic hold_taken    = 1'b0;
  int   hold_left     = 0;
  int   chars_sent    = 0;

  logic [CHAR_W-1:0] text[$];

  postfix_expression_evaluator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  postfix_eval_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .answers_due   (answers_due)
  );

  always #2 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Offer one character word and hold it until accepted
  task automatic send_word(input logic [CHAR_W-1:0] c, input logic is_last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= is_last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic ship();
    for (int i = 0; i < text.size(); i++) send_word(text[i], i == text.size() - 1);
    text.delete();
  endtask

  // Drop valid and wait until every predicted result word has arrived
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (answers_due != 0) @(posedge clk);
  endtask

  task automatic put(input logic [CHAR_W-1:0] c);
    text.push_back(c);
  endtask

  task automatic put_num(input longint unsigned n);
    logic [CHAR_W-1:0] rev[$];
    do begin
      rev.push_back(CH_ZERO + CHAR_W'(n % 10));
      n = n / 10;
    end while (n != 0);
    while (rev.size() != 0) put(rev.pop_back());
  endtask

  // Mostly small numbers, some wide ones and some digit runs that wrap
  task automatic put_random_number();
    int r;
    r = $urandom_range(99);
    if (r < 40)      put_num($urandom_range(9));
    else if (r < 70) put_num($urandom_range(99));
    else if (r < 85) put_num($urandom_range(99999));
    else if (r < 95) put_num($urandom);
    else repeat ($urandom_range(10, 12)) put(CH_ZERO + CHAR_W'($urandom_range(9)));
  endtask

  function automatic logic [CHAR_W-1:0] rand_op();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // Valid postfix text with random operands, operators and spacing
  task automatic build_wellformed(input int max_depth, input int n_ops);
    int   depth, ops;
    logic prev_num;
    depth    = 0;
    ops      = 0;
    prev_num = 1'b0;
    while (ops < n_ops || depth != 1) begin
      if (depth < 2 || (ops < n_ops && depth < max_depth && $urandom_range(1) == 0)) begin
        if (prev_num || $urandom_range(9) == 0) put(CH_SPACE);
        put_random_number();
        prev_num = 1'b1;
        depth++;
      end else begin
        if (prev_num && $urandom_range(1) == 1) put(CH_SPACE);
        put(rand_op());
        prev_num = 1'b0;
        depth--;
        ops++;
      end
    end
    if ($urandom_range(7) == 0) put(CH_SPACE);
  endtask

  // Push around the stack depth, then fold or leave a trailing digit run
  task automatic build_deep();
    int k;
    k = $urandom_range(30, 34);
    repeat (k) begin
      put_num($urandom_range(9));
      put(CH_SPACE);
    end
    if ($urandom_range(1) == 0) begin
      repeat (k - 1) put($urandom_range(1) ? CH_PLUS : CH_STAR);
    end else begin
      put_num($urandom_range(9));
    end
  endtask

  // Most negative value divided by minus one
  task automatic build_min_div();
    put_num(64'd2147483648);
    put(CH_SPACE);
    put_num(0);
    put(CH_SPACE);
    put_num(1);
    put(CH_MINUS);
    put(CH_SLASH);
  endtask

  // Valid text with one character dropped, inserted or overwritten
  task automatic build_broken();
    build_wellformed(4, $urandom_range(1, 5));
    case ($urandom_range(2))
      0: if (text.size() > 1) text.delete($urandom_range(text.size() - 1));
      1: text.insert($urandom_range(text.size()), rand_op());
      default: text[$urandom_range(text.size() - 1)] = CHAR_W'($urandom_range(255));
    endcase
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(3))
        0: put(CHAR_W'($urandom_range(255)));
        1: put(CH_ZERO + CHAR_W'($urandom_range(9)));
        2: put(CH_SPACE);
        default: put(rand_op());
      endcase
    end
  endtask

  // Stimulus and verdict
  initial begin
    int expr_idx, mode, phase;
    logic paused;
    expr_idx = 0;
    paused   = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: every operator, each status except full stack, extreme character codes
    put_num(9); put(CH_SPACE); put_num(3); put(CH_SLASH); put_num(2); put(CH_STAR);
    put_num(1); put(CH_PLUS); ship();
    put_num(5); put(CH_SPACE); put_num(7); put(CH_MINUS); ship();
    put(CH_PLUS); ship();
    put_num(1); put(CH_SPACE); put_num(2); ship();
    put_num(1); put(CH_SPACE); put_num(0); put(CH_SLASH); ship();
    put('0); ship();
    put('1); put(CH_PLUS); ship();
    put(CH_SPACE); ship();
    put_num(0); ship();
    wait_drained();

    // Random expressions through the idling phases
    while (chars_sent < CHARS_TARGET) begin
      phase = (chars_sent / PHASE_CHARS) % 4;
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 79; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 79; end
        default: begin src_idle_pct = 30; snk_stall_pct = 30; end
      endcase
      if (chars_sent >= 600 && !hold_req) hold_req <= 1'b1;
      if (chars_sent >= 1100 && !paused) begin
        wait_drained();
        paused = 1'b1;
      end
      mode = (expr_idx < 4) ? expr_idx : $urandom_range(99);
      case (1'b1)
        (expr_idx < 4 && mode == 0), (expr_idx >= 4 && mode >= 24 && mode < 84):
          build_wellformed($urandom_range(2, 8), $urandom_range(0, 7));
        (expr_idx < 4 && mode == 1), (expr_idx >= 4 && mode < 6):
          build_deep();
        (expr_idx < 4 && mode == 2), (expr_idx >= 4 && mode >= 6 && mode < 10):
          build_min_div();
        (expr_idx < 4 && mode == 3), (expr_idx >= 4 && mode >= 10 && mode < 24):
          build_broken();
        default:
          build_noise();
      endcase
      ship();
      expr_idx++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && answers_due == 0) begin
      $display("postfix_expression_evaluator_unit: match");
    end else begin
      $display("postfix_expression_evaluator_unit: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("postfix_expression_evaluator_unit: mismatch");
    $finish;
  end

endmodule
